[rtl/core/text_cell_writer_wrap_scroll_core_defines.svh]
// Assertion macros for the text-cell writer core.
// Used by the top level only; needs signals clk and rst in the using scope.
`ifndef TEXT_CELL_WRITER_WRAP_SCROLL_CORE_DEFINES_SVH
`define TEXT_CELL_WRITER_WRAP_SCROLL_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, cond, consq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
    else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
// Shared types, constants and codes of the text-cell writer core.
// No dependencies; imported by tcw_sweep and the top level.
package tcw_pkg;

  localparam int DefCols = 48;
  localparam int DefRows = 27;

  localparam logic [4:0]  BLINK_LAST = 5'd29;
  localparam logic [15:0] CH_SPACE   = 16'd32;
  localparam logic [15:0] CH_NEWLINE = 16'd10;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEF_FG     = 3'd0;
  localparam logic [2:0] REG_DEF_BG     = 3'd1;
  localparam logic [2:0] REG_DEF_ATTRS  = 3'd2;
  localparam logic [2:0] REG_MARGIN_BOT = 3'd3;
  localparam logic [2:0] REG_MARGIN_LFT = 3'd4;
  localparam logic [2:0] REG_MARGIN_RGT = 3'd5;
  localparam logic [2:0] REG_AUTO_SCRL  = 3'd6;

  // Request action codes.
  localparam logic [3:0] ACT_STREAM    = 4'd0;
  localparam logic [3:0] ACT_START     = 4'd1;
  localparam logic [3:0] ACT_SET_CUR   = 4'd2;
  localparam logic [3:0] ACT_PUT_DEF   = 4'd3;
  localparam logic [3:0] ACT_PUT_STY   = 4'd4;
  localparam logic [3:0] ACT_READ      = 4'd5;
  localparam logic [3:0] ACT_SCRL_UP   = 4'd6;
  localparam logic [3:0] ACT_SCRL_DN   = 4'd7;
  localparam logic [3:0] ACT_SCRL_LFT  = 4'd8;
  localparam logic [3:0] ACT_SCRL_RGT  = 4'd9;
  localparam logic [3:0] ACT_CLEAR     = 4'd10;
  localparam logic [3:0] ACT_CLEAR_ROW = 4'd11;
  localparam logic [3:0] ACT_TICK      = 4'd12;

  // Sweep operations.
  localparam logic [2:0] SW_FILL  = 3'd0;
  localparam logic [2:0] SW_UP    = 3'd1;
  localparam logic [2:0] SW_DOWN  = 3'd2;
  localparam logic [2:0] SW_LEFT  = 3'd3;
  localparam logic [2:0] SW_RIGHT = 3'd4;

  // What the write stage stores for one sweep step.
  localparam logic [1:0] KIND_BLANK = 2'd0;
  localparam logic [1:0] KIND_COPY  = 2'd1;
  localparam logic [1:0] KIND_EDGE  = 2'd2;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [7:0]  attrs;
  } cell_t;

  typedef struct packed {
    logic       busy;
    logic       rd_en;
    logic [1:0] kind;
  } sweep_ctl_t;

endpackage

[rtl/core/tcw_sweep.sv]
// Address sequencer that walks the cell store for scrolls and fills.
// Depends on tcw_pkg; one step per cycle, source and destination per step.
module tcw_sweep
  import tcw_pkg::*;
#(
  parameter int TEXT_COLS = DefCols,
  parameter int TEXT_ROWS = DefRows,
  localparam int CW = $clog2(TEXT_COLS),
  localparam int RW = $clog2(TEXT_ROWS),
  localparam int AW = $clog2(TEXT_COLS * TEXT_ROWS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    start_op,
  input  logic [AW-1:0] start_addr,
  input  logic [RW-1:0] start_row,
  input  logic [CW-1:0] start_col,
  input  logic [AW-1:0] end_addr,
  output sweep_ctl_t    ctl,
  output logic [AW-1:0] dest_addr,
  output logic [AW-1:0] src_addr
);

  logic          busy;
  logic [2:0]    op;
  logic [AW-1:0] addr;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] last_addr;
  logic          desc;
  logic [1:0]    kind;

  assign desc = (op == SW_DOWN) || (op == SW_RIGHT);

  // Source cell and step kind for the current position.
  always_comb begin
    kind     = KIND_BLANK;
    src_addr = addr;
    case (op)
      SW_UP: begin
        if (row != RW'(TEXT_ROWS - 1)) begin
          kind     = KIND_COPY;
          src_addr = addr + AW'(TEXT_COLS);
        end
      end
      SW_DOWN: begin
        if (row != '0) begin
          kind     = KIND_COPY;
          src_addr = addr - AW'(TEXT_COLS);
        end
      end
      SW_LEFT: begin
        if (col == CW'(TEXT_COLS - 1)) begin
          kind = KIND_EDGE;
        end else begin
          kind     = KIND_COPY;
          src_addr = addr + AW'(1);
        end
      end
      SW_RIGHT: begin
        if (col == '0) begin
          kind = KIND_EDGE;
        end else begin
          kind     = KIND_COPY;
          src_addr = addr - AW'(1);
        end
      end
      default: kind = KIND_BLANK;
    endcase
  end

  assign dest_addr = addr;
  assign ctl.busy  = busy;
  assign ctl.rd_en = busy && (kind != KIND_BLANK);
  assign ctl.kind  = kind;

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      op        <= SW_FILL;
      addr      <= '0;
      row       <= '0;
      col       <= '0;
      last_addr <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      op        <= start_op;
      addr      <= start_addr;
      row       <= start_row;
      col       <= start_col;
      last_addr <= end_addr;
    end else if (busy) begin
      if (addr == last_addr) begin
        busy <= 1'b0;
      end else if (desc) begin
        addr <= addr - AW'(1);
        if (col == '0) begin
          col <= CW'(TEXT_COLS - 1);
          row <= row - RW'(1);
        end else begin
          col <= col - CW'(1);
        end
      end else begin
        addr <= addr + AW'(1);
        if (col == CW'(TEXT_COLS - 1)) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

endmodule

[rtl/core/text_cell_writer_wrap_scroll_core.sv]
// Top level of the text-cell writer: cell store, cursor, blink and control.
// Depends on tcw_pkg, tcw_sweep and text_cell_writer_wrap_scroll_core_defines.svh.
//
//  Channel  Handshake            Carries
//  in       in_valid/in_ready    action, pos_col, pos_row, char_code, colors, attributes
//  out      out_valid/out_ready  cell fields, cursor, blink phase, halt flag
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// Simple requests (cursor, put, read, tick, stream without scroll) make the store access,
// then load the output register. Scrolls, clear screen and a stream that scrolls walk
// every cell, one per cycle; clear row walks the cells of one row. After reset a clearing
// pass zeroes the store, and in_ready stays low until it is over. A stalled output holds
// the next result in its final cycle.
module text_cell_writer_wrap_scroll_core
  import tcw_pkg::*;
#(
  parameter int TEXT_COLS = DefCols,
  parameter int TEXT_ROWS = DefRows
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [7:0]  pos_col,
  input  logic [7:0]  pos_row,
  input  logic [15:0] char_code,
  input  logic [7:0]  fg_in,
  input  logic [7:0]  bg_in,
  input  logic [7:0]  attributes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] cell_code,
  output logic [7:0]  cell_fg,
  output logic [7:0]  cell_bg,
  output logic [7:0]  cell_attrs,
  output logic [7:0]  cur_col_now,
  output logic [7:0]  cur_row_now,
  output logic        cursor_shown,
  output logic        halted_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  `include "text_cell_writer_wrap_scroll_core_defines.svh"

  localparam int CW    = $clog2(TEXT_COLS);
  localparam int RW    = $clog2(TEXT_ROWS);
  localparam int CELLS = TEXT_COLS * TEXT_ROWS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Configuration registers.
  logic [7:0] dflt_fg, dflt_bg, dflt_attrs;
  logic [4:0] margin_bot;
  logic [5:0] margin_left, margin_right;
  logic       scroll_en;

  // Control state.
  logic [1:0] state;
  logic       init_pass;
  logic [7:0] cur_col, cur_row;
  logic       string_halted, cursor_on;
  logic [4:0] blink_count;
  logic       res_read;

  // Cell store and its registered read data.
  cell_t mem [CELLS];
  cell_t rd_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  cell_t         mem_wdata;

  // Write stage of the sweep pipeline.
  logic          p_valid;
  logic [1:0]    p_kind;
  logic [AW-1:0] p_addr;
  cell_t         blank;

  // Sweep sequencer interface.
  sweep_ctl_t    sw_ctl;
  logic [AW-1:0] sw_dest, sw_src;
  logic          sw_start;
  logic [2:0]    sw_op;
  logic [AW-1:0] sw_saddr, sw_eaddr;
  logic [RW-1:0] sw_srow;
  logic [CW-1:0] sw_scol;
  cell_t         sw_blank;

  tcw_sweep #(
    .TEXT_COLS(TEXT_COLS),
    .TEXT_ROWS(TEXT_ROWS)
  ) u_sweep (
    .clk       (clk),
    .rst       (rst),
    .start     (sw_start),
    .start_op  (sw_op),
    .start_addr(sw_saddr),
    .start_row (sw_srow),
    .start_col (sw_scol),
    .end_addr  (sw_eaddr),
    .ctl       (sw_ctl),
    .dest_addr (sw_dest),
    .src_addr  (sw_src)
  );

  // Effective margins and request decode.
  logic [7:0]    eff_bottom, eff_left, eff_right;
  logic          acc, pos_in, cur_in;
  logic [AW-1:0] pos_row_base, pos_addr, cur_addr;
  logic [7:0]    col_inc, row_inc;
  logic          do_stream, is_nl, wrap, adv, past;

  assign eff_bottom = ({3'b0, margin_bot} < 8'(TEXT_ROWS)) ? {3'b0, margin_bot}
                                                           : 8'(TEXT_ROWS - 1);
  assign eff_left   = ({2'b0, margin_left} < 8'(TEXT_COLS)) ? {2'b0, margin_left} : 8'd0;
  assign eff_right  = ({2'b0, margin_right} < 8'(TEXT_COLS)) ? {2'b0, margin_right}
                                                             : 8'(TEXT_COLS - 1);

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;

  assign pos_in       = (pos_col < 8'(TEXT_COLS)) && (pos_row < 8'(TEXT_ROWS));
  assign cur_in       = (cur_col < 8'(TEXT_COLS)) && (cur_row < 8'(TEXT_ROWS));
  assign pos_row_base = AW'(pos_row[RW-1:0]) * AW'(TEXT_COLS);
  assign pos_addr     = pos_row_base + AW'(pos_col[CW-1:0]);
  assign cur_addr     = AW'(cur_row[RW-1:0]) * AW'(TEXT_COLS) + AW'(cur_col[CW-1:0]);

  // Streamed character: newline, wrap and bottom-margin handling.
  assign do_stream = !string_halted && (char_code != '0);
  assign is_nl     = (char_code == CH_NEWLINE);
  assign col_inc   = cur_col + 8'd1;
  assign row_inc   = cur_row + 8'd1;
  assign wrap      = !is_nl && (col_inc > eff_right);
  assign adv       = is_nl || wrap;
  assign past      = row_inc > eff_bottom;

  // Request-side store access and sweep start.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pos_addr;
    mem_raddr = pos_addr;
    mem_wdata = '{code: char_code, fg: dflt_fg, bg: dflt_bg, attrs: dflt_attrs};
    sw_start  = 1'b0;
    sw_op     = SW_FILL;
    sw_saddr  = '0;
    sw_srow   = '0;
    sw_scol   = '0;
    sw_eaddr  = AW'(CELLS - 1);
    sw_blank  = '{code: CH_SPACE, fg: dflt_fg, bg: dflt_bg, attrs: dflt_attrs};
    if (state == ST_INIT) begin
      sw_start = 1'b1;
      sw_blank = '0;
    end else if (acc) begin
      case (action)
        ACT_STREAM: begin
          if (do_stream) begin
            mem_we    = !is_nl && cur_in;
            mem_waddr = cur_addr;
            sw_start  = adv && past && scroll_en;
            sw_op     = SW_UP;
          end
        end
        ACT_PUT_DEF: mem_we = pos_in;
        ACT_PUT_STY: begin
          mem_we    = pos_in;
          mem_wdata = '{code: char_code, fg: fg_in, bg: bg_in, attrs: attributes};
        end
        ACT_READ: mem_re = pos_in;
        ACT_SCRL_UP: begin
          sw_start = 1'b1;
          sw_op    = SW_UP;
        end
        ACT_SCRL_LFT: begin
          sw_start = 1'b1;
          sw_op    = SW_LEFT;
        end
        ACT_SCRL_DN, ACT_SCRL_RGT: begin
          sw_start = 1'b1;
          sw_op    = (action == ACT_SCRL_DN) ? SW_DOWN : SW_RIGHT;
          sw_saddr = AW'(CELLS - 1);
          sw_srow  = RW'(TEXT_ROWS - 1);
          sw_scol  = CW'(TEXT_COLS - 1);
          sw_eaddr = '0;
        end
        ACT_CLEAR: begin
          sw_start = 1'b1;
          sw_blank = '{code: CH_SPACE, fg: dflt_fg, bg: bg_in, attrs: dflt_attrs};
        end
        ACT_CLEAR_ROW: begin
          sw_start = pos_row < 8'(TEXT_ROWS);
          sw_saddr = pos_row_base;
          sw_srow  = pos_row[RW-1:0];
          sw_eaddr = pos_row_base + AW'(TEXT_COLS - 1);
          sw_blank = '{code: CH_SPACE, fg: dflt_fg, bg: bg_in, attrs: dflt_attrs};
        end
        default: ;
      endcase
    end else if (sw_ctl.rd_en) begin
      mem_re    = 1'b1;
      mem_raddr = sw_src;
    end
    // The sweep write stage owns the port whenever it holds a step.
    if (p_valid) begin
      mem_we    = 1'b1;
      mem_waddr = p_addr;
      case (p_kind)
        KIND_COPY: mem_wdata = rd_q;
        KIND_EDGE: mem_wdata = '{code: blank.code, fg: blank.fg, bg: blank.bg,
                                 attrs: rd_q.attrs};
        default:   mem_wdata = blank;
      endcase
    end
  end

  // Cell store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Sweep write stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= sw_ctl.busy;
    end
    p_kind <= sw_ctl.kind;
    p_addr <= sw_dest;
    if (sw_start) begin
      blank <= sw_blank;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_fg      <= 8'd15;
      dflt_bg      <= 8'd0;
      dflt_attrs   <= 8'd0;
      margin_bot   <= 5'd26;
      margin_left  <= 6'd0;
      margin_right <= 6'd47;
      scroll_en    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEF_FG:     dflt_fg      <= cfg_data;
        REG_DEF_BG:     dflt_bg      <= cfg_data;
        REG_DEF_ATTRS:  dflt_attrs   <= cfg_data;
        REG_MARGIN_BOT: margin_bot   <= cfg_data[4:0];
        REG_MARGIN_LFT: margin_left  <= cfg_data[5:0];
        REG_MARGIN_RGT: margin_right <= cfg_data[5:0];
        REG_AUTO_SCRL:  scroll_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Cursor, halt flag, blink and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      init_pass     <= 1'b1;
      cur_col       <= '0;
      cur_row       <= '0;
      string_halted <= 1'b0;
      blink_count   <= '0;
      cursor_on     <= 1'b1;
      res_read      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // A result is loaded in the final cycle; otherwise a taken result clears valid.
      if ((state == ST_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: state <= ST_BUSY;
        ST_IDLE: begin
          if (acc) begin
            init_pass <= 1'b0;
            res_read  <= (action == ACT_READ) && pos_in;
            state     <= sw_start ? ST_BUSY : ST_FIN;
            case (action)
              ACT_STREAM: begin
                if (do_stream) begin
                  if (adv) begin
                    cur_col <= eff_left;
                    if (!past) begin
                      cur_row <= row_inc;
                    end else if (scroll_en || !wrap) begin
                      cur_row <= eff_bottom;
                    end else begin
                      cur_row <= row_inc;
                    end
                    if (past && !scroll_en) begin
                      string_halted <= 1'b1;
                    end
                  end else begin
                    cur_col <= col_inc;
                  end
                end
              end
              ACT_START: begin
                cur_col       <= pos_col;
                cur_row       <= pos_row;
                string_halted <= 1'b0;
              end
              ACT_SET_CUR: begin
                cur_col <= (pos_col < 8'(TEXT_COLS)) ? pos_col : 8'(TEXT_COLS - 1);
                cur_row <= (pos_row < 8'(TEXT_ROWS)) ? pos_row : 8'(TEXT_ROWS - 1);
              end
              ACT_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
              end
              ACT_TICK: begin
                if (blink_count == BLINK_LAST) begin
                  blink_count <= '0;
                  cursor_on   <= !cursor_on;
                end else begin
                  blink_count <= blink_count + 5'd1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_BUSY: begin
          if (!sw_ctl.busy && !p_valid) begin
            state <= init_pass ? ST_IDLE : ST_FIN;
          end
        end
        default: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Output register, loaded as the result leaves the final cycle.
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && (!out_valid || out_ready)) begin
      cell_code    <= res_read ? rd_q.code  : '0;
      cell_fg      <= res_read ? rd_q.fg    : '0;
      cell_bg      <= res_read ? rd_q.bg    : '0;
      cell_attrs   <= res_read ? rd_q.attrs : '0;
      cur_col_now  <= cur_col;
      cur_row_now  <= cur_row;
      cursor_shown <= cursor_on;
      halted_now   <= string_halted;
    end
  end

  // A request is only taken while no sweep step is in flight.
  `TCW_ASSERT_NOW(a_idle_no_sweep, in_ready, !sw_ctl.busy && !p_valid, "request taken during sweep")
  // Sweep steps always reach the write stage in the next cycle.
  `TCW_ASSERT_NEXT(a_sweep_pipe, sw_ctl.busy, p_valid, "sweep step lost before write")
  // A read request reaches ST_FIN in the very next cycle.
  `TCW_ASSERT_NEXT(a_read_fin, acc && (action == ACT_READ), state == ST_FIN, "read did not finish")

endmodule
